// ===== hdl/svpd_pkg.sv =====
// Shared constants, types and helpers for the space vector PWM duty unit.
`timescale 1ns / 1ps
`default_nettype none
package svpd_pkg;

	localparam int FRAC_BITS = 15;
	localparam int IN_W      = 16;
	localparam int DUTY_W    = 16;
	localparam int DW        = FRAC_BITS + 21;
	localparam int SQ_W      = 2 * IN_W;

	function automatic longint unsigned isqrt64(input longint unsigned n);
		longint unsigned rem;
		longint unsigned res;
		longint unsigned bitv;
		rem  = n;
		res  = 0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bitv != 0) begin
				if (rem >= res + bitv) begin
					rem = rem - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	localparam longint unsigned INV_SQRT3_L =
		(isqrt64((64'd1 << (2 * FRAC_BITS + 2)) / 3) + 64'd1) >> 1;
	localparam logic signed [FRAC_BITS+1:0] INV_SQRT3 = (FRAC_BITS + 2)'(INV_SQRT3_L);

	localparam logic signed [DW-1:0] ONE_T     = DW'(1) <<< (15 + FRAC_BITS);
	localparam logic signed [DW-1:0] FULL_T    = DW'(1) <<< (16 + FRAC_BITS);
	localparam logic signed [DW-1:0] HALF_LSB  = DW'(1) <<< FRAC_BITS;
	localparam logic [DUTY_W-1:0]    DUTY_FULL = DUTY_W'(32768);
	localparam logic [DUTY_W-1:0]    DUTY_HALF = DUTY_W'(16384);

	typedef enum logic [2:0] {
		SECTOR_0 = 3'd0,
		SECTOR_1 = 3'd1,
		SECTOR_2 = 3'd2,
		SECTOR_3 = 3'd3,
		SECTOR_4 = 3'd4,
		SECTOR_5 = 3'd5
	} sector_t;

	typedef struct packed {
		logic    valid;
		logic    en;
		sector_t sector;
	} svpd_ctrl_t;

	function automatic logic [DUTY_W-1:0] to_duty(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] r;
		r = v + HALF_LSB;
		if (v <= 0)
			return '0;
		else if (v >= FULL_T)
			return DUTY_FULL;
		else
			return r[FRAC_BITS+1 +: DUTY_W];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/svpd_sector.sv =====
// Sector search and scaled-reference product stage.
`timescale 1ns / 1ps
`default_nettype none
module svpd_sector
	import svpd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire svpd_ctrl_t              ctrl_in,
	input  wire logic signed [IN_W-1:0]  a_in,
	input  wire logic signed [IN_W-1:0]  b_in,
	output      svpd_ctrl_t              ctrl_s2,
	output      logic signed [IN_W-1:0]  a_s2,
	output      logic signed [DW-1:0]    y_s2
);

	logic [SQ_W-1:0]   a_sq;
	logic [SQ_W-1:0]   b_sq;
	logic [SQ_W+1:0]   a_sq3;
	logic              steep;
	logic              upper;
	sector_t           sector;
	logic signed [DW-1:0] y;

	always_comb begin
		a_sq  = unsigned'(SQ_W'(a_in * a_in));
		b_sq  = unsigned'(SQ_W'(b_in * b_in));
		a_sq3 = {1'b0, a_sq, 1'b0} + {2'b00, a_sq};
		steep = {2'b00, b_sq} >= a_sq3;
		upper = (b_in > 0) || ((b_in == 0) && (a_in > 0));
		y     = DW'(b_in * INV_SQRT3);
		if ((a_in == 0) && (b_in == 0))
			sector = SECTOR_0;
		else if (upper)
			sector = steep ? SECTOR_1 : ((a_in > 0) ? SECTOR_0 : SECTOR_2);
		else
			sector = steep ? SECTOR_4 : ((a_in < 0) ? SECTOR_3 : SECTOR_5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2.valid  <= ctrl_in.valid;
			ctrl_s2.en     <= ctrl_in.en;
			ctrl_s2.sector <= sector;
		end
	end

	always_ff @(posedge clk) begin
		a_s2 <= a_in;
		y_s2 <= y;
	end

endmodule
`default_nettype wire

// ===== hdl/svpd_times.sv =====
// Active-vector times and doubled phase duties, two register stages.
`timescale 1ns / 1ps
`default_nettype none
module svpd_times
	import svpd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire svpd_ctrl_t             ctrl_in,
	input  wire logic signed [IN_W-1:0] a_in,
	input  wire logic signed [DW-1:0]   y_in,
	output      svpd_ctrl_t             ctrl_s4,
	output      logic signed [DW-1:0]   da_s4,
	output      logic signed [DW-1:0]   db_s4,
	output      logic signed [DW-1:0]   dc_s4
);

	svpd_ctrl_t           ctrl_s3;
	logic signed [DW-1:0] big_a;
	logic signed [DW-1:0] t1;
	logic signed [DW-1:0] t2;
	logic signed [DW-1:0] t1_s3;
	logic signed [DW-1:0] t2_s3;
	logic signed [DW-1:0] d0;
	logic signed [DW-1:0] d1;
	logic signed [DW-1:0] d2;
	logic signed [DW-1:0] da;
	logic signed [DW-1:0] db;
	logic signed [DW-1:0] dc;

	always_comb begin
		big_a = DW'(a_in) <<< FRAC_BITS;
		case (ctrl_in.sector)
			SECTOR_0: begin t1 = big_a - y_in;   t2 = y_in <<< 1;     end
			SECTOR_1: begin t1 = y_in - big_a;   t2 = big_a + y_in;   end
			SECTOR_2: begin t1 = y_in <<< 1;     t2 = -y_in - big_a;  end
			SECTOR_3: begin t1 = -(y_in <<< 1);  t2 = y_in - big_a;   end
			SECTOR_4: begin t1 = -big_a - y_in;  t2 = big_a - y_in;   end
			default:  begin t1 = big_a + y_in;   t2 = -(y_in <<< 1);  end
		endcase
	end

	always_comb begin
		d0 = ONE_T - t1_s3 - t2_s3;
		d1 = ONE_T + t1_s3 - t2_s3;
		d2 = ONE_T + t1_s3 + t2_s3;
		case (ctrl_s3.sector)
			SECTOR_0: begin da = d0; db = d1; dc = d2; end
			SECTOR_1: begin db = d0; da = d1; dc = d2; end
			SECTOR_2: begin db = d0; dc = d1; da = d2; end
			SECTOR_3: begin dc = d0; db = d1; da = d2; end
			SECTOR_4: begin dc = d0; da = d1; db = d2; end
			default:  begin da = d0; dc = d1; db = d2; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			ctrl_s3 <= ctrl_in;
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		t1_s3 <= t1;
		t2_s3 <= t2;
		da_s4 <= da;
		db_s4 <= db;
		dc_s4 <= dc;
	end

endmodule
`default_nettype wire

// ===== hdl/svpd_round.sv =====
// Duty rounding, saturation and result register.
`timescale 1ns / 1ps
`default_nettype none
module svpd_round
	import svpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire svpd_ctrl_t            ctrl_in,
	input  wire logic signed [DW-1:0]  da_in,
	input  wire logic signed [DW-1:0]  db_in,
	input  wire logic signed [DW-1:0]  dc_in,
	output      logic                  done_q,
	output      logic [DUTY_W-1:0]     duty_a_q,
	output      logic [DUTY_W-1:0]     duty_b_q,
	output      logic [DUTY_W-1:0]     duty_c_q,
	output      logic [2:0]            sector_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_in.en) begin
			duty_a_q <= to_duty(da_in);
			duty_b_q <= to_duty(db_in);
			duty_c_q <= to_duty(dc_in);
			sector_q <= ctrl_in.sector;
		end else begin
			duty_a_q <= DUTY_HALF;
			duty_b_q <= DUTY_HALF;
			duty_c_q <= DUTY_HALF;
			sector_q <= SECTOR_0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/space_vector_pwm_duty_unit.sv =====
// Space vector PWM duty unit: top level.
//
// Usage: drive modulation_on, volt_alpha and volt_beta (Q1.15) with start high;
// the item is taken at that clock edge because busy is always low. Any number
// of items may follow in consecutive cycles, one per clock.
// Results: done is high for exactly one cycle with duty_phase_a/b/c (32768 is
// full period, saturated to 0..32768) and sector_number (0..5). done rises
// once the item has passed the pipeline below. Results come out in order.
// Throughput: one item per clock, through the five-register
// pipeline (input, sector/product, times, phase duties, result).
// With modulation_on low all duties are 16384 and sector_number is 0.
// The receiver cannot stall: done lasts one cycle and must be taken then.
// Reset (arst_n low) clears all valid flags; items in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none
module space_vector_pwm_duty_unit
	import svpd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output      logic                   busy,
	input  wire logic                   modulation_on,
	input  wire logic signed [IN_W-1:0] volt_alpha,
	input  wire logic signed [IN_W-1:0] volt_beta,
	output      logic                   done,
	output      logic [DUTY_W-1:0]      duty_phase_a,
	output      logic [DUTY_W-1:0]      duty_phase_b,
	output      logic [DUTY_W-1:0]      duty_phase_c,
	output      logic [2:0]             sector_number
);

	svpd_ctrl_t           ctrl_s1;
	svpd_ctrl_t           ctrl_s2;
	svpd_ctrl_t           ctrl_s4;
	logic signed [IN_W-1:0] a_s1;
	logic signed [IN_W-1:0] b_s1;
	logic signed [IN_W-1:0] a_s2;
	logic signed [DW-1:0]   y_s2;
	logic signed [DW-1:0]   da_s4;
	logic signed [DW-1:0]   db_s4;
	logic signed [DW-1:0]   dc_s4;

	assign busy = 1'b0;

	// hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid  <= start && !busy;
			ctrl_s1.en     <= modulation_on;
			ctrl_s1.sector <= SECTOR_0;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= volt_alpha;
		b_s1 <= volt_beta;
	end

	svpd_sector u_sector (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_in (ctrl_s1),
		.a_in    (a_s1),
		.b_in    (b_s1),
		.ctrl_s2 (ctrl_s2),
		.a_s2    (a_s2),
		.y_s2    (y_s2)
	);

	svpd_times u_times (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_in (ctrl_s2),
		.a_in    (a_s2),
		.y_in    (y_s2),
		.ctrl_s4 (ctrl_s4),
		.da_s4   (da_s4),
		.db_s4   (db_s4),
		.dc_s4   (dc_s4)
	);

	svpd_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (ctrl_s4),
		.da_in    (da_s4),
		.db_in    (db_s4),
		.dc_in    (dc_s4),
		.done_q   (done),
		.duty_a_q (duty_phase_a),
		.duty_b_q (duty_phase_b),
		.duty_c_q (duty_phase_c),
		.sector_q (sector_number)
	);

endmodule
`default_nettype wire

// ===== hdl/svpd_checker.sv =====
// Port-level checks for the space vector PWM duty unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module svpd_checker
	import svpd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   modulation_on,
	input wire logic                   done,
	input wire logic [DUTY_W-1:0]      duty_phase_a,
	input wire logic [DUTY_W-1:0]      duty_phase_b,
	input wire logic [DUTY_W-1:0]      duty_phase_c,
	input wire logic [2:0]             sector_number
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without an accepted item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sector_number <= 3'd5 && duty_phase_a <= DUTY_FULL &&
			duty_phase_b <= DUTY_FULL && duty_phase_c <= DUTY_FULL))
		else $error("result field out of range");

	a_disabled_half: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(modulation_on, 5)) |-> (sector_number == 3'd0 &&
			duty_phase_a == DUTY_HALF && duty_phase_b == DUTY_HALF &&
			duty_phase_c == DUTY_HALF))
		else $error("disabled item did not give half duties");

endmodule

bind space_vector_pwm_duty_unit svpd_checker u_svpd_checker (.*);
`default_nettype wire
